@@ rtl/dbrs_pkg.sv @@
// Shared types and constants of the dirty buffer run sorter.
// Used by dbrs_key_cmp and dirty_buffer_run_sorter; no dependencies.
`timescale 1ns / 1ps

package dbrs_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_POOL_SIZE    = 2'd0;
    localparam logic [1:0] REG_FIRST_VICTIM = 2'd1;
    localparam logic [1:0] REG_KEEP_GROUP   = 2'd2;

    localparam logic [29:0] DIST_MAX = 30'h3FFF_FFFF;

    // one stored entry
    typedef struct packed {
        logic [29:0] index;
        logic [31:0] space;
        logic [31:0] database;
        logic [31:0] relation;
        logic [1:0]  fork_no;
        logic [31:0] block;
    } t_entry;

    // entry in file order, with its distance and run continuation flag
    typedef struct packed {
        t_entry      e;
        logic [29:0] run_dist;
        logic        cont;
    } t_pos;

    // sort key, most significant field first
    typedef struct packed {
        logic [31:0] space;
        logic [31:0] database;
        logic [31:0] relation;
        logic [1:0]  fork_no;
        logic [31:0] block;
    } t_key;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK_A,
        ST_RANK_LOAD,
        ST_RANK_SCAN,
        ST_RANK_WRITE,
        ST_FWD_ORD,
        ST_FWD_ENT,
        ST_FWD_WR,
        ST_BWD_RD,
        ST_BWD_WR,
        ST_OUT_ORD,
        ST_OUT_POS,
        ST_OUT_EMIT
    } t_state;

endpackage

@@ rtl/dirty_buffer_run_sorter.sv @@
// Top level of the dirty buffer run sorter: entry store, sort passes, output.
// Depends on dbrs_pkg and dbrs_key_cmp.
`timescale 1ns / 1ps

// Entries are loaded one per cycle while busy is low. A beat with last_in
// starts the batch of n entries: a rank sort by file and block
// (one store read per comparison), a forward pass building the
// file-ordered copy with each run's running minimum distance, a backward
// pass spreading each run's smallest distance, unless keep_file_grouping
// is set a second rank sort by distance and block, then the n results,
// each read from the file-ordered store before it is strobed.
// The rank scan's pace is set by the single read port of each store.
// Results are strobed on o_valid for one cycle each and cannot be stalled;
// busy stays high until the beat marked last_out. An entry arriving with
// the store full is dropped.
module dirty_buffer_run_sorter
    import dbrs_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [29:0] i_buffer_index,
    input  logic [31:0] i_space_id,
    input  logic [31:0] i_database_id,
    input  logic [31:0] i_relation_id,
    input  logic [1:0]  i_fork_number,
    input  logic [31:0] i_block_number,
    input  logic        i_last_in,
    output logic        o_valid,
    output logic [29:0] o_out_buffer_index,
    output logic [31:0] o_out_space_id,
    output logic [31:0] o_out_database_id,
    output logic [31:0] o_out_relation_id,
    output logic [1:0]  o_out_fork_number,
    output logic [31:0] o_out_block_number,
    output logic [29:0] o_run_distance,
    output logic        o_last_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

    // configuration
    logic [30:0] r_pool_size;
    logic [29:0] r_first_victim;
    logic        r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size    <= 31'd16384;
            r_first_victim <= '0;
            r_keep         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POOL_SIZE:    r_pool_size    <= i_cfg_data;
                REG_FIRST_VICTIM: r_first_victim <= i_cfg_data[29:0];
                REG_KEEP_GROUP:   r_keep         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories: entries in load order, entries in file order, slot order
    t_entry        ent_mem [MAX_ENTRIES];
    t_pos          pos_mem [MAX_ENTRIES];
    logic [AW-1:0] ord_mem [MAX_ENTRIES];

    t_entry        r_ent_rdata;
    t_pos          r_pos_rdata;
    logic [AW-1:0] r_ord_rdata;

    logic          ent_we, pos_we, ord_we;
    logic [AW-1:0] ent_waddr, pos_waddr, ord_waddr;
    logic [AW-1:0] ent_raddr, pos_raddr, ord_raddr;
    t_entry        ent_wdata;
    t_pos          pos_wdata;
    logic [AW-1:0] ord_wdata;

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        r_ent_rdata <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
        r_pos_rdata <= pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
        r_ord_rdata <= ord_mem[ord_raddr];
    end

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_last;
    logic [AW-1:0] r_i, r_j, r_k, r_rank;
    logic          r_sort2;
    t_key          r_key_a;
    logic [29:0]   r_min;
    logic [29:0]   r_fmin;
    logic          r_next_cont;
    logic [31:0]   r_prev_block;
    t_key          r_prev_file;

    logic accept;
    logic loadable;
    assign accept   = start && !busy;
    assign loadable = (r_count < COUNT_MAX);

    // key of the word currently read for the active sort
    t_key rd_key;
    always_comb begin
        if (r_sort2) begin
            rd_key = '0;
            rd_key.space = {2'b00, r_pos_rdata.run_dist};
            rd_key.block = r_pos_rdata.e.block;
        end else begin
            rd_key.space    = r_ent_rdata.space;
            rd_key.database = r_ent_rdata.database;
            rd_key.relation = r_ent_rdata.relation;
            rd_key.fork_no  = r_ent_rdata.fork_no;
            rd_key.block    = r_ent_rdata.block;
        end
    end

    t_cmp cmp_ba;
    dbrs_key_cmp u_cmp (
        .i_a   (rd_key),
        .i_b   (r_key_a),
        .o_cmp (cmp_ba)
    );

    logic goes_first;
    assign goes_first = cmp_ba.lt || (cmp_ba.eq && (r_j < r_i));

    // eviction distance of the entry read in the forward pass
    logic [32:0] dist_wrap;
    logic [29:0] fwd_dist;
    always_comb begin
        dist_wrap = {3'b000, r_ent_rdata.index} + {2'b00, r_pool_size}
                    - {3'b000, r_first_victim};
        if (r_ent_rdata.index >= r_first_victim) begin
            fwd_dist = r_ent_rdata.index - r_first_victim;
        end else if (dist_wrap[32] || (dist_wrap[31:0] > {2'b00, DIST_MAX})) begin
            fwd_dist = DIST_MAX;
        end else begin
            fwd_dist = dist_wrap[29:0];
        end
    end

    // run continuation: same file and the next block, without wrap
    logic        fwd_cont;
    logic [32:0] prev_succ;
    t_key        cur_file;
    always_comb begin
        cur_file          = '0;
        cur_file.space    = r_ent_rdata.space;
        cur_file.database = r_ent_rdata.database;
        cur_file.relation = r_ent_rdata.relation;
        cur_file.fork_no  = r_ent_rdata.fork_no;
        prev_succ = {1'b0, r_prev_block} + 33'd1;
        fwd_cont  = (r_k != '0) && (cur_file == r_prev_file)
                    && (prev_succ == {1'b0, r_ent_rdata.block});
    end

    // forward pass: smallest distance so far within the run
    logic [29:0] fwd_min;
    always_comb begin
        if (fwd_cont && (r_fmin < fwd_dist)) fwd_min = r_fmin;
        else fwd_min = fwd_dist;
    end

    // backward pass: smallest distance so far within the run
    logic [29:0] bwd_min;
    always_comb begin
        if (r_next_cont && (r_min < r_pos_rdata.run_dist)) bwd_min = r_min;
        else bwd_min = r_pos_rdata.run_dist;
    end

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        ent_we    = 1'b0;
        ent_waddr = r_count[AW-1:0];
        ent_wdata = '{index: i_buffer_index, space: i_space_id,
                      database: i_database_id, relation: i_relation_id,
                      fork_no: i_fork_number, block: i_block_number};
        pos_we    = 1'b0;
        pos_waddr = r_k;
        pos_wdata = '{e: r_ent_rdata, run_dist: fwd_min, cont: fwd_cont};
        ord_we    = 1'b0;
        ord_waddr = r_rank;
        ord_wdata = r_i;
        ent_raddr = r_i;
        pos_raddr = r_i;
        ord_raddr = r_k;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    ent_we = loadable;
                    if (i_last_in) n_state = ST_RANK_A;
                end
            end
            ST_RANK_A: n_state = ST_RANK_LOAD;
            ST_RANK_LOAD: begin
                ent_raddr = '0;
                pos_raddr = '0;
                n_state   = ST_RANK_SCAN;
            end
            ST_RANK_SCAN: begin
                ent_raddr = r_j + 1'b1;
                pos_raddr = r_j + 1'b1;
                if (r_j == r_last) n_state = ST_RANK_WRITE;
            end
            ST_RANK_WRITE: begin
                ord_we = 1'b1;
                if (r_i == r_last) n_state = r_sort2 ? ST_OUT_ORD : ST_FWD_ORD;
                else n_state = ST_RANK_A;
            end
            ST_FWD_ORD: n_state = ST_FWD_ENT;
            ST_FWD_ENT: begin
                ent_raddr = r_ord_rdata;
                n_state   = ST_FWD_WR;
            end
            ST_FWD_WR: begin
                pos_we = 1'b1;
                if (r_k == r_last) n_state = ST_BWD_RD;
                else n_state = ST_FWD_ORD;
            end
            ST_BWD_RD: begin
                pos_raddr = r_k;
                n_state   = ST_BWD_WR;
            end
            ST_BWD_WR: begin
                pos_we    = 1'b1;
                pos_wdata = '{e: r_pos_rdata.e, run_dist: bwd_min,
                              cont: r_pos_rdata.cont};
                if (r_k != '0) n_state = ST_BWD_RD;
                else if (r_keep) n_state = ST_OUT_ORD;
                else n_state = ST_RANK_A;
            end
            ST_OUT_ORD: n_state = ST_OUT_POS;
            ST_OUT_POS: begin
                pos_raddr = r_keep ? r_k : r_ord_rdata;
                n_state   = ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
                if (r_k == r_last) n_state = ST_IDLE;
                else n_state = ST_OUT_ORD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // counters and pass registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_rank      <= '0;
            r_sort2     <= 1'b0;
            r_next_cont <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (loadable) r_count <= r_count + 1'b1;
                        if (i_last_in) begin
                            r_last  <= loadable ? r_count[AW-1:0]
                                                : AW'(r_count - 1'b1);
                            r_i     <= '0;
                            r_sort2 <= 1'b0;
                        end
                    end
                end
                ST_RANK_LOAD: begin
                    r_key_a <= rd_key;
                    r_j     <= '0;
                    r_rank  <= '0;
                end
                ST_RANK_SCAN: begin
                    if (goes_first) r_rank <= r_rank + 1'b1;
                    r_j <= r_j + 1'b1;
                end
                ST_RANK_WRITE: begin
                    r_i <= r_i + 1'b1;
                    r_k <= '0;
                end
                ST_FWD_WR: begin
                    r_prev_file  <= cur_file;
                    r_prev_block <= r_ent_rdata.block;
                    r_fmin       <= fwd_min;
                    r_next_cont  <= 1'b0;
                    if (r_k != r_last) r_k <= r_k + 1'b1;
                end
                ST_BWD_WR: begin
                    r_min       <= bwd_min;
                    r_next_cont <= r_pos_rdata.cont;
                    if (r_k != '0) r_k <= r_k - 1'b1;
                    r_sort2 <= 1'b1;
                    r_i     <= '0;
                end
                ST_OUT_EMIT: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == r_last) r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // outputs
    assign busy               = (r_state != ST_IDLE);
    assign o_valid            = (r_state == ST_OUT_EMIT);
    assign o_out_buffer_index = r_pos_rdata.e.index;
    assign o_out_space_id     = r_pos_rdata.e.space;
    assign o_out_database_id  = r_pos_rdata.e.database;
    assign o_out_relation_id  = r_pos_rdata.e.relation;
    assign o_out_fork_number  = r_pos_rdata.e.fork_no;
    assign o_out_block_number = r_pos_rdata.e.block;
    assign o_run_distance     = r_pos_rdata.run_dist;
    assign o_last_out         = o_valid && (r_k == r_last);

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX) else $error("entry count beyond store depth");

    a_last_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |=> !busy && (r_count == '0))
        else $error("batch not closed after final beat");

    a_no_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid) else $error("result beat while idle");

    a_batch_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_in) |=> (r_count != '0))
        else $error("batch started with an empty store");

endmodule

@@ rtl/dbrs_key_cmp.sv @@
// Lexicographic comparator of two sort keys.
// Depends on dbrs_pkg.
`timescale 1ns / 1ps

module dbrs_key_cmp
    import dbrs_pkg::*;
(
    input  t_key i_a,
    input  t_key i_b,
    output t_cmp o_cmp
);

    localparam int KEY_W = $bits(t_key);

    logic [KEY_W-1:0] w_a;
    logic [KEY_W-1:0] w_b;

    // fields are packed most significant first, so a plain compare is numeric order
    always_comb begin
        w_a = KEY_W'(i_a);
        w_b = KEY_W'(i_b);
        o_cmp.lt = (w_a < w_b);
        o_cmp.eq = (w_a == w_b);
    end

endmodule

@@ sim/dirty_buffer_run_sorter_tb.sv @@
// Self-checking testbench for dirty_buffer_run_sorter: batches of dirty entries
// are loaded under several register settings and the sorted output is checked.
// Depends on dbrs_pkg and the dirty_buffer_run_sorter RTL.
`timescale 1ns / 1ps

module dirty_buffer_run_sorter_tb;
    import dbrs_pkg::*;

    localparam int DEPTH      = 64;
    localparam int STALL_LIM  = 100000;

    // one expected output beat
    typedef struct {
        t_entry      e;
        logic [29:0] rdist;
        logic        last;
    } t_sorted_beat;

    // Scoreboard: mirrors the store and predicts each batch's sorted order
    class run_sort_board;
        t_entry       held[$];
        t_sorted_beat expected[$];
        logic [30:0]  pool_size = 31'd16384;
        logic [29:0]  victim    = '0;
        logic         keep_group = 1'b0;
        int           mismatches = 0;

        function logic [29:0] evict_gap(logic [29:0] idx);
            logic [63:0] d;
            if (idx >= victim) d = 64'(idx) - 64'(victim);
            else               d = 64'(idx) + 64'(pool_size) - 64'(victim);
            if (d > 64'(DIST_MAX)) d = 64'(DIST_MAX);
            return d[29:0];
        endfunction

        function logic [97:0] file_key(t_entry e);
            return {e.space, e.database, e.relation, e.fork_no};
        endfunction

        function void note_entry(t_entry e, bit last);
            int          ord[$];
            logic [29:0] gap[$];
            logic [129:0] ka, kb;
            int          n, i, j, v;
            logic [29:0] mind, d;
            t_sorted_beat b;
            if (held.size() < DEPTH) held.push_back(e);
            if (!last) return;
            n = held.size();
            for (i = 0; i < n; i++) begin
                ord.push_back(i);
                gap.push_back('0);
            end
            // stable insertion sort by file tag then block
            for (i = 1; i < n; i++) begin
                v = ord[i];
                j = i;
                while (j > 0) begin
                    ka = {file_key(held[ord[j-1]]), held[ord[j-1]].block};
                    kb = {file_key(held[v]), held[v].block};
                    if (ka <= kb) break;
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = v;
            end
            // each run of consecutive blocks takes its smallest distance
            i = 0;
            while (i < n) begin
                mind = evict_gap(held[ord[i]].index);
                j = i + 1;
                while (j < n && file_key(held[ord[j-1]]) == file_key(held[ord[j]]) &&
                       {1'b0, held[ord[j-1]].block} + 33'd1 == {1'b0, held[ord[j]].block}) begin
                    d = evict_gap(held[ord[j]].index);
                    if (d < mind) mind = d;
                    j++;
                end
                for (; i < j; i++) gap[ord[i]] = mind;
            end
            // optional stable re-sort by run distance then block
            if (!keep_group) begin
                for (i = 1; i < n; i++) begin
                    v = ord[i];
                    j = i;
                    while (j > 0) begin
                        if ({gap[ord[j-1]], held[ord[j-1]].block} <=
                            {gap[v], held[v].block}) break;
                        ord[j] = ord[j-1];
                        j--;
                    end
                    ord[j] = v;
                end
            end
            for (i = 0; i < n; i++) begin
                b.e     = held[ord[i]];
                b.rdist = gap[ord[i]];
                b.last  = (i == n - 1);
                expected.push_back(b);
            end
            held.delete();
        endfunction

        function void check_beat(t_entry e, logic [29:0] rdist, logic last);
            t_sorted_beat x;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p dist=%0d last=%0b", e, rdist, last);
                return;
            end
            x = expected.pop_front();
            if (x.e !== e || x.rdist !== rdist || x.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %p dist=%0d last=%0b / got %p dist=%0d last=%0b",
                             x.e, x.rdist, x.last, e, rdist, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [29:0] i_buffer_index = '0;
    logic [31:0] i_space_id = '0;
    logic [31:0] i_database_id = '0;
    logic [31:0] i_relation_id = '0;
    logic [1:0]  i_fork_number = '0;
    logic [31:0] i_block_number = '0;
    logic        i_last_in = 1'b0;
    logic        o_valid;
    logic [29:0] o_out_buffer_index;
    logic [31:0] o_out_space_id;
    logic [31:0] o_out_database_id;
    logic [31:0] o_out_relation_id;
    logic [1:0]  o_out_fork_number;
    logic [31:0] o_out_block_number;
    logic [29:0] o_run_distance;
    logic        o_last_out;

    run_sort_board board = new();
    bit            gaps_on = 1'b1;
    int            stall_count = 0;
    int            items_sent = 0;

    dirty_buffer_run_sorter #(.MAX_ENTRIES(DEPTH)) i_dut (.*);

    always #1 i_clk = ~i_clk;

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_entry got;
        if (i_rst_n && o_valid) begin
            got = '{o_out_buffer_index, o_out_space_id, o_out_database_id,
                    o_out_relation_id, o_out_fork_number, o_out_block_number};
            board.check_beat(got, o_run_distance, o_last_out);
        end
        if ((start && !busy) || o_valid) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count > STALL_LIM) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one beat into the entry store
    task automatic send_entry(t_entry e, bit last);
        while (gaps_on && $urandom_range(99) < 30) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_buffer_index <= e.index;
        i_space_id     <= e.space;
        i_database_id  <= e.database;
        i_relation_id  <= e.relation;
        i_fork_number  <= e.fork_no;
        i_block_number <= e.block;
        i_last_in      <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_entry(e, last);
        items_sent++;
    endtask

    // hold off until the block is idle and every beat is back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || board.expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_POOL_SIZE)         board.pool_size  = val;
        else if (idx == REG_FIRST_VICTIM) board.victim     = val[29:0];
        else if (idx == REG_KEEP_GROUP)   board.keep_group = val[0];
    endtask

    task automatic set_regs(logic [30:0] pool, logic [29:0] vic, bit keep);
        write_reg(REG_POOL_SIZE, pool);
        write_reg(REG_FIRST_VICTIM, {1'b0, vic});
        write_reg(REG_KEEP_GROUP, {30'd0, keep});
        @(posedge i_clk);
    endtask

    // random batch: mostly a few files with clustered blocks so runs form
    task automatic random_batch(int n);
        t_entry files[3];
        t_entry e;
        int     k;
        for (k = 0; k < 3; k++) begin
            files[k].space    = $urandom_range(3) == 0 ? $urandom : $urandom_range(1);
            files[k].database = $urandom_range(3) == 0 ? $urandom : $urandom_range(1);
            files[k].relation = $urandom_range(1) == 0 ? $urandom : $urandom_range(2);
            files[k].fork_no  = $urandom_range(3);
            files[k].block    = $urandom_range(4) == 0 ? 32'hFFFF_FFF8 | $urandom_range(7)
                                                      : $urandom_range(40);
        end
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) begin
                e = files[$urandom_range(2)];
                e.block = e.block + $urandom_range(6);
            end else begin
                e = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            e.index = $urandom_range(1) ? $urandom : $urandom_range(board.pool_size + 3);
            send_entry(e, k == n - 1);
        end
    endtask

    initial begin
        t_entry d[$];
        int     p, target, n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_regs(31'd16384, 30'd0, 1'b0);

        // directed: field extremes, runs, duplicates, no wrap past the top block
        d.push_back('{30'd5,  32'd0, 32'd0, 32'd0, 2'd0, 32'd7});
        d.push_back('{30'd9,  32'd0, 32'd0, 32'd0, 2'd0, 32'd5});
        d.push_back('{30'd2,  32'd0, 32'd0, 32'd0, 2'd0, 32'd6});
        d.push_back('{30'd1,  32'd0, 32'd0, 32'd0, 2'd0, 32'd6});
        d.push_back('{30'h3FFF_FFFF, 32'd0, 32'd0, 32'd0, 2'd0, 32'hFFFF_FFFF});
        d.push_back('{30'd0,  32'd0, 32'd0, 32'd0, 2'd0, 32'd0});
        d.push_back('{30'd20000, '1, '1, '1, 2'd3, 32'd10});
        d.push_back('{30'd3,  '1, '1, '1, 2'd3, 32'd11});
        d.push_back('{30'd8,  32'd0, 32'd0, 32'd0, 2'd1, 32'd6});
        d.push_back('{30'd8,  32'd0, 32'd0, 32'd0, 2'd2, 32'd6});
        d.push_back('{30'd8,  32'd0, 32'd1, 32'd0, 2'd0, 32'd6});
        d.push_back('{30'd8,  32'd1, 32'd0, 32'd0, 2'd0, 32'd6});
        d.push_back('{30'd8,  32'd0, 32'd0, 32'd1, 2'd0, 32'd7});
        d.push_back('{30'd4,  32'd0, 32'd0, 32'd0, 2'd0, 32'd8});
        foreach (d[k]) send_entry(d[k], k == d.size() - 1);
        send_entry('{30'd16383, 32'd7, 32'd7, 32'd7, 2'd1, 32'd42}, 1'b1);
        drain();

        // random phases under varied settings, the extremes among them
        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_regs(31'd1, 30'd0, 1'b1);
                1: set_regs(31'h4000_0000, 30'h3FFF_FFFF, 1'b0);
                2: set_regs(31'h7FFF_FFFF, 30'h3FFF_FFFF, 1'b1);
                3: set_regs(31'd1000, 30'd500, 1'b0);
                default: set_regs($urandom_range(1 << 20, 1), $urandom_range(1 << 20),
                                  $urandom_range(1));
            endcase
            gaps_on = (p != 2);
            target  = items_sent + 77;
            while (items_sent < target) begin
                if ((p == 1 || p == 4) && items_sent + 66 >= target)
                    n = $urandom_range(66, 60);  // near or beyond the store depth, may overflow
                else
                    n = $urandom_range(12, 1);
                random_batch(n);
            end
            drain();
        end

        start <= 1'b0;
        while (board.expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected.size() == 0 && board.held.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ dirty_buffer_run_sorter.f @@
rtl/dbrs_pkg.sv
rtl/dbrs_key_cmp.sv
rtl/dirty_buffer_run_sorter.sv
sim/dirty_buffer_run_sorter_tb.sv
